### rtl/uer_pkg.sv
package uer_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_HEADER_WORDS_DEF = 41;
    localparam int COUNTER_BITS_DEF     = 32;

    // The IHL nibble is 4 bits wide, so byte offsets inside the header stay below 128.
    localparam int HL_W   = 4;
    localparam int BYTE_W = HL_W + 4;

    // Stream widths.
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 120;

    // Protocol constants.
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
    localparam logic [BYTE_W-1:0] MIN_FRAME_BYTES = BYTE_W'(42);
    localparam logic [HL_W-1:0]   MIN_IHL = HL_W'(5);

    // Verdict codes.
    typedef logic [2:0] verdict_t;
    localparam verdict_t VERD_ECHO      = 3'd0;
    localparam verdict_t VERD_SHORT     = 3'd1;
    localparam verdict_t VERD_NOT_IPV4  = 3'd2;
    localparam verdict_t VERD_NOT_UDP   = 3'd3;
    localparam verdict_t VERD_PORT      = 3'd4;
    localparam verdict_t VERD_MALFORMED = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_collect;
        logic take_pass;
        logic take_skip;
        logic flush_read;
        logic flush_load;
        logic load_report;
    } uer_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
        logic decide_now;
        logic match_now;
        logic flush_last;
    } uer_stat_t;

endpackage

### rtl/uer_ctrl.sv
module uer_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    output uer_pkg::uer_cmd_t cmd,
    input  uer_pkg::uer_stat_t stat
);
    import uer_pkg::*;

    typedef enum logic [5:0] {
        ST_COLLECT  = 6'b000001,
        ST_DISCARD  = 6'b000010,
        ST_PASS     = 6'b000100,
        ST_FLUSH_RD = 6'b001000,
        ST_FLUSH_LD = 6'b010000,
        ST_REPORT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   eof_pend_reg, eof_pend_next;
    logic   take;

    // Items are taken only in the streaming states and with the output register empty.
    assign s_tready = (state_reg == ST_COLLECT || state_reg == ST_DISCARD ||
                       state_reg == ST_PASS) && !stat.out_busy;
    assign take = s_tvalid && s_tready;

    // Next state and command decode.
    always_comb begin
        state_next    = state_reg;
        eof_pend_next = eof_pend_reg;
        cmd           = '0;
        case (state_reg)
            ST_COLLECT: begin
                cmd.take_collect = take;
                if (take && stat.decide_now) begin
                    if (stat.match_now) begin
                        eof_pend_next = s_tlast;
                        state_next    = ST_FLUSH_RD;
                    end else if (s_tlast) begin
                        state_next = ST_REPORT;
                    end else begin
                        state_next = ST_DISCARD;
                    end
                end
            end
            ST_DISCARD: begin
                cmd.take_skip = take;
                if (take && s_tlast) begin
                    state_next = ST_REPORT;
                end
            end
            ST_PASS: begin
                cmd.take_pass = take;
                if (take && s_tlast) begin
                    state_next = ST_REPORT;
                end
            end
            ST_FLUSH_RD: begin
                if (!stat.out_busy) begin
                    cmd.flush_read = 1'b1;
                    state_next     = ST_FLUSH_LD;
                end
            end
            ST_FLUSH_LD: begin
                cmd.flush_load = 1'b1;
                if (stat.flush_last) begin
                    state_next = eof_pend_reg ? ST_REPORT : ST_PASS;
                end else begin
                    state_next = ST_FLUSH_RD;
                end
            end
            ST_REPORT: begin
                if (!stat.out_busy) begin
                    cmd.load_report = 1'b1;
                    state_next      = ST_COLLECT;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_COLLECT;
            eof_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            eof_pend_reg <= eof_pend_next;
        end
    end

endmodule

### rtl/uer_dp.sv
module uer_dp #(
    parameter int MAX_HEADER_WORDS = uer_pkg::MAX_HEADER_WORDS_DEF,
    parameter int COUNTER_BITS     = uer_pkg::COUNTER_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [uer_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [uer_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                             m_tuser,
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [15:0]                      cfg_data,
    input  uer_pkg::uer_cmd_t                cmd,
    output uer_pkg::uer_stat_t               stat
);
    import uer_pkg::*;

    localparam int AW = $clog2(MAX_HEADER_WORDS);
    localparam int CW = $clog2(MAX_HEADER_WORDS + 1);
    localparam logic [BYTE_W-1:0] MAXH_B = BYTE_W'(MAX_HEADER_WORDS);

    // Header buffer.
    logic [15:0] hdr_mem [MAX_HEADER_WORDS];
    logic [15:0] rd_data_reg;

    logic [15:0]           listen_reg;
    logic [CW-1:0]         wcnt_reg;
    logic [HL_W-1:0]       hl_reg, hl_next;
    logic [15:0]           csum_reg;
    logic [15:0]           eth_reg, dport_reg;
    logic [7:0]            proto_reg;
    verdict_t              verdict_reg;
    logic [AW-1:0]         fidx_reg;
    logic [COUNTER_BITS-1:0] rx_cnt_reg, match_cnt_reg, drop_cnt_reg;

    logic                  out_valid_reg, out_kind_reg, out_last_reg;
    logic [15:0]           out_word_reg;
    logic [1:0]            out_bytes_reg;
    verdict_t              out_verdict_reg;
    logic [31:0]           out_rx_reg, out_match_reg, out_drop_reg;

    logic                  odd_last;
    logic [15:0]           word_m;
    logic [1:0]            nb;
    logic [BYTE_W-1:0]     idx_b, bp_new, hl_b, need_b, full_b, req_b, u_b, fidx_b, src_b;
    logic                  hdr_ok, decide_now, take_any;
    verdict_t              verdict_now, verdict_final;
    logic [16:0]           sum17;
    logic [15:0]           csum_fold;
    logic                  csum_use;
    logic [15:0]           flush_word;

    assign cfg_ready = 1'b1;

    // Input word: an odd final word keeps only its high byte.
    assign odd_last = s_tlast && (s_tdata[17:16] == 2'd1);
    assign word_m   = odd_last ? {s_tdata[15:8], 8'h00} : s_tdata[15:0];
    assign nb       = odd_last ? 2'd1 : 2'd2;
    assign take_any = cmd.take_collect || cmd.take_pass || cmd.take_skip;

    // Byte arithmetic on the header layout.
    assign idx_b  = BYTE_W'(wcnt_reg);
    assign bp_new = {idx_b[BYTE_W-2:0], 1'b0} + BYTE_W'(nb);
    assign hl_b   = BYTE_W'(hl_reg);
    assign need_b = BYTE_W'(11) + {hl_b[BYTE_W-2:0], 1'b0};
    assign full_b = {need_b[BYTE_W-2:0], 1'b0};
    assign u_b    = need_b - BYTE_W'(4);
    assign hdr_ok = (hl_reg >= MIN_IHL) && (need_b <= MAXH_B);
    assign req_b  = hdr_ok ? full_b : MIN_FRAME_BYTES;
    assign decide_now = (bp_new >= req_b) || s_tlast;

    // Frame classification from the captured header fields.
    always_comb begin
        if (bp_new < MIN_FRAME_BYTES) begin
            verdict_now = VERD_SHORT;
        end else if (eth_reg != ETH_TYPE_IPV4) begin
            verdict_now = VERD_NOT_IPV4;
        end else if (proto_reg != IP_PROTO_UDP) begin
            verdict_now = VERD_NOT_UDP;
        end else if (!hdr_ok || bp_new < full_b) begin
            verdict_now = VERD_MALFORMED;
        end else if (dport_reg != listen_reg) begin
            verdict_now = VERD_PORT;
        end else begin
            verdict_now = VERD_ECHO;
        end
    end

    assign verdict_final = cmd.take_collect ? verdict_now : verdict_reg;

    // Running ones-complement sum over the IPv4 header, checksum word excluded.
    assign csum_use = (idx_b == BYTE_W'(7)) ||
                      ((idx_b > BYTE_W'(7)) && (idx_b < u_b) && (idx_b != BYTE_W'(12)));
    assign sum17     = {1'b0, csum_reg} + {1'b0, word_m};
    assign csum_fold = sum17[15:0] + 16'(sum17[16]);

    // Source word for each output position of the rewritten header.
    assign fidx_b = BYTE_W'(fidx_reg);
    always_comb begin
        if (fidx_b < BYTE_W'(3)) begin
            src_b = fidx_b + BYTE_W'(3);
        end else if (fidx_b < BYTE_W'(6)) begin
            src_b = fidx_b - BYTE_W'(3);
        end else if (fidx_b == BYTE_W'(13) || fidx_b == BYTE_W'(14)) begin
            src_b = fidx_b + BYTE_W'(2);
        end else if (fidx_b == BYTE_W'(15) || fidx_b == BYTE_W'(16)) begin
            src_b = fidx_b - BYTE_W'(2);
        end else if (fidx_b == u_b) begin
            src_b = u_b + BYTE_W'(1);
        end else if (fidx_b == u_b + BYTE_W'(1)) begin
            src_b = u_b;
        end else begin
            src_b = fidx_b;
        end
    end

    // Checksum and UDP checksum positions are generated, not read.
    always_comb begin
        if (fidx_b == BYTE_W'(12)) begin
            flush_word = ~csum_reg;
        end else if (fidx_b == u_b + BYTE_W'(3)) begin
            flush_word = 16'h0000;
        end else begin
            flush_word = rd_data_reg;
        end
    end

    // Header buffer write and registered read.
    always_ff @(posedge aclk) begin
        if (cmd.take_collect && wcnt_reg < CW'(MAX_HEADER_WORDS)) begin
            hdr_mem[wcnt_reg[AW-1:0]] <= word_m;
        end
        if (cmd.flush_read) begin
            rd_data_reg <= hdr_mem[src_b[AW-1:0]];
        end
    end

    assign hl_next = (idx_b == BYTE_W'(7)) ? word_m[11:8] : hl_reg;

    // Header capture registers; the word count, IHL and checksum sum are cleared when a frame's report goes out.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcnt_reg    <= '0;
            hl_reg      <= '0;
            csum_reg    <= '0;
            verdict_reg <= VERD_ECHO;
            fidx_reg    <= '0;
            listen_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                listen_reg <= cfg_data;
            end
            if (cmd.load_report) begin
                wcnt_reg <= '0;
                hl_reg   <= '0;
                csum_reg <= '0;
            end else if (cmd.take_collect) begin
                wcnt_reg <= wcnt_reg + CW'(1);
                hl_reg   <= hl_next;
                if (csum_use) begin
                    csum_reg <= csum_fold;
                end
                if (decide_now) begin
                    verdict_reg <= verdict_now;
                    fidx_reg    <= '0;
                end
            end else if (cmd.flush_load) begin
                fidx_reg <= fidx_reg + AW'(1);
            end
        end
    end

    // Header fields needed for the decision.
    always_ff @(posedge aclk) begin
        if (cmd.take_collect) begin
            if (idx_b == BYTE_W'(6)) begin
                eth_reg <= word_m;
            end
            if (idx_b == BYTE_W'(11)) begin
                proto_reg <= word_m[7:0];
            end
            if (idx_b == u_b + BYTE_W'(1)) begin
                dport_reg <= word_m;
            end
        end
    end

    // Frame counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_cnt_reg    <= '0;
            match_cnt_reg <= '0;
            drop_cnt_reg  <= '0;
        end else begin
            if (take_any && s_tlast) begin
                rx_cnt_reg <= rx_cnt_reg + COUNTER_BITS'(1);
                if (verdict_final == VERD_SHORT) begin
                    drop_cnt_reg <= drop_cnt_reg + COUNTER_BITS'(1);
                end
            end
            if (cmd.take_collect && decide_now && verdict_now == VERD_ECHO) begin
                match_cnt_reg <= match_cnt_reg + COUNTER_BITS'(1);
            end
        end
    end

    // Output register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.take_pass || cmd.flush_load || cmd.load_report) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (cmd.take_pass || cmd.flush_load) begin
            out_kind_reg    <= 1'b0;
            out_last_reg    <= 1'b0;
            out_word_reg    <= cmd.take_pass ? word_m : flush_word;
            out_bytes_reg   <= cmd.take_pass ? nb : 2'd2;
            out_verdict_reg <= VERD_ECHO;
            out_rx_reg      <= '0;
            out_match_reg   <= '0;
            out_drop_reg    <= '0;
        end else if (cmd.load_report) begin
            out_kind_reg    <= 1'b1;
            out_last_reg    <= 1'b1;
            out_word_reg    <= '0;
            out_bytes_reg   <= '0;
            out_verdict_reg <= verdict_reg;
            out_rx_reg      <= 32'(rx_cnt_reg);
            out_match_reg   <= 32'(match_cnt_reg);
            out_drop_reg    <= 32'(drop_cnt_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_drop_reg, out_match_reg, out_rx_reg,
                       out_verdict_reg, out_bytes_reg, out_word_reg};

    assign stat.out_busy   = out_valid_reg;
    assign stat.decide_now = decide_now;
    assign stat.match_now  = (verdict_now == VERD_ECHO);
    assign stat.flush_last = (fidx_b == need_b - BYTE_W'(1));

endmodule

### rtl/udp_echo_responder.sv
// A passed word appears in the cycle after it is taken; a frame's report is loaded from
// ST_REPORT into the output register once the output is free.
// Throughput: one item per cycle while the header is collected or a frame is discarded
// and the output register is empty; a passed item waits until the single output
// register empties; a matched frame's rewritten header is read back from the buffer.
// Reset: synchronous, active low; clears control state, counters and listen_port.
module udp_echo_responder #(
    parameter int MAX_HEADER_WORDS = uer_pkg::MAX_HEADER_WORDS_DEF,
    parameter int COUNTER_BITS     = uer_pkg::COUNTER_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] frame_word, [17:16] valid_bytes
    input  logic [uer_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] echo_word, [17:16] echo_bytes, [20:18] verdict, [52:21] received_total,
    // [84:53] matched_total, [116:85] dropped_total
    output logic [uer_pkg::OUT_DATA_W-1:0] m_tdata,
    // [0] result_kind
    output logic                           m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [15:0]                    cfg_data
);
    import uer_pkg::*;

    uer_cmd_t  cmd;
    uer_stat_t stat;

    uer_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    uer_dp #(
        .MAX_HEADER_WORDS (MAX_HEADER_WORDS),
        .COUNTER_BITS     (COUNTER_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

### rtl/uer_checker.sv
module uer_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic [uer_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic                           m_tuser,
    input logic                           m_tlast
);

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The output comes up empty after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // No item is taken while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready with output pending");

    // Reports carry no word and always close the run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata[17:0] == 18'd0))
        else $error("malformed report");

    // Echoed words carry no verdict or counters.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> !m_tlast && (m_tdata[116:18] == 99'd0))
        else $error("malformed echo word");

endmodule

bind udp_echo_responder uer_checker u_uer_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
